/* design/swtf_pkg.sv */
`timescale 1ns / 1ps
// shared constants, types and helper functions for the sliding window trend fit
// no dependencies
package swtf_pkg;

  localparam int MAX_WINDOW = 512;
  localparam int IDX_W      = $clog2(MAX_WINDOW);
  localparam int CNT_W      = 10;
  localparam int SAMPLE_W   = 32;
  localparam int SY_W       = 42;
  localparam int SW_W       = 52;
  localparam int SX_W       = 17;
  localparam int SXX_W      = 26;
  localparam int PY_W       = CNT_W + SAMPLE_W + 1;
  localparam int HALF_W     = 26;
  localparam int CHUNK_W    = HALF_W + 1;
  localparam int PROD_W     = 2 * CHUNK_W;
  localparam int ACC_W      = 72;
  localparam int D_W        = 33;
  localparam int DD_W       = D_W + 1;
  localparam int FRAC_SH    = 17;
  localparam int DIV_W      = 90;
  localparam int DIV_STEPS  = DIV_W / 2;
  localparam int DCNT_W     = $clog2(DIV_STEPS);
  localparam int RES_W      = 48;
  localparam int OP_W       = 4;

  localparam logic [CNT_W-1:0] WIN_MIN   = CNT_W'(2);
  localparam logic [CNT_W-1:0] WIN_MAX   = CNT_W'(MAX_WINDOW);
  localparam logic [CNT_W-1:0] WIN_RESET = CNT_W'(365);

  typedef enum logic [1:0] {
    SM_N,
    SM_SX,
    SM_SXX
  } small_e;

  typedef enum logic [1:0] {
    WD_SXX,
    WD_SX,
    WD_SW,
    WD_SY
  } wide_e;

  typedef enum logic [1:0] {
    GRP_DEN,
    GRP_SLOPE,
    GRP_ICPT
  } group_e;

  typedef struct packed {
    small_e     sm;
    wide_e      wd;
    logic       hi;
    logic       sub;
  } op_t;

  typedef struct packed {
    logic            accept;
    logic            prod_y;
    logic            upd_sums;
    logic            mul;
    logic            acc;
    logic            cap_d;
    logic            div_start;
    logic            cap_res;
    logic            out_load;
    logic [OP_W-1:0] op;
  } cmd_t;

  typedef struct packed {
    logic fit_ok;
    logic div_busy;
  } status_t;

  function automatic logic [CNT_W-1:0] clamp_window(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    r = v;
    if (v < WIN_MIN) r = WIN_MIN;
    else if (v > WIN_MAX) r = WIN_MAX;
    return r;
  endfunction

  function automatic op_t op_decode(input logic [OP_W-1:0] op);
    op_t o;
    o.hi  = op[0];
    o.sub = op[1];
    case (op[3:2])
      GRP_DEN: begin
        o.sm = op[1] ? SM_SX : SM_N;
        o.wd = op[1] ? WD_SX : WD_SXX;
      end
      GRP_SLOPE: begin
        o.sm = op[1] ? SM_SX : SM_N;
        o.wd = op[1] ? WD_SY : WD_SW;
      end
      default: begin
        o.sm = op[1] ? SM_SX : SM_SXX;
        o.wd = op[1] ? WD_SW : WD_SY;
      end
    endcase
    return o;
  endfunction

endpackage

/* design/swtf_div.sv */
`timescale 1ns / 1ps
// restoring unsigned divider, two quotient bits per cycle, saturating quotient flag
// depends on swtf_pkg
module swtf_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [swtf_pkg::DIV_W-1:0]    dividend_i,
  input  logic [swtf_pkg::DD_W-1:0]     divisor_i,
  output logic                          busy_o,
  output logic [swtf_pkg::RES_W-1:0]    quot_o,
  output logic                          ovf_o
);

  logic                          busy_q;
  logic [swtf_pkg::DCNT_W-1:0]   cnt_q;
  logic [swtf_pkg::DIV_W-1:0]    dvd_q, dvd_d;
  logic [swtf_pkg::DD_W-1:0]     dvs_q;
  logic [swtf_pkg::DD_W-1:0]     rem_q, rem_d;
  logic [swtf_pkg::RES_W-1:0]    quo_q, quo_d;
  logic                          ovf_q, ovf_d;

  always_comb begin
    logic [swtf_pkg::DD_W:0] r;
    rem_d = rem_q;
    quo_d = quo_q;
    ovf_d = ovf_q;
    dvd_d = dvd_q;
    for (int k = 0; k < 2; k++) begin
      r = {rem_d, dvd_d[swtf_pkg::DIV_W-1]};
      dvd_d = {dvd_d[swtf_pkg::DIV_W-2:0], 1'b0};
      ovf_d = ovf_d | quo_d[swtf_pkg::RES_W-1];
      if (r >= {1'b0, dvs_q}) begin
        r = r - {1'b0, dvs_q};
        quo_d = {quo_d[swtf_pkg::RES_W-2:0], 1'b1};
      end else begin
        quo_d = {quo_d[swtf_pkg::RES_W-2:0], 1'b0};
      end
      rem_d = r[swtf_pkg::DD_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == swtf_pkg::DCNT_W'(swtf_pkg::DIV_STEPS - 1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
      quo_q <= '0;
      ovf_q <= 1'b0;
    end else if (busy_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
      quo_q <= quo_d;
      ovf_q <= ovf_d;
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;
  assign ovf_o  = ovf_q;

endmodule

/* design/swtf_dp.sv */
`timescale 1ns / 1ps
// datapath: sample ring, running sums, shared multiplier, accumulator, result registers
// depends on swtf_pkg and swtf_div
module swtf_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  swtf_pkg::cmd_t                    cmd_i,
  output swtf_pkg::status_t                 status_o,
  input  logic                              cfg_we_i,
  input  logic [swtf_pkg::CNT_W-1:0]        cfg_wdata_i,
  input  logic signed [swtf_pkg::SAMPLE_W-1:0] balance_sample_i,
  output logic signed [swtf_pkg::RES_W-1:0] trend_slope_o,
  output logic signed [swtf_pkg::RES_W-1:0] trend_intercept_o,
  output logic                              fit_valid_o,
  output logic [swtf_pkg::CNT_W-1:0]        samples_held_o
);

  logic [swtf_pkg::SAMPLE_W-1:0]        ring_q [swtf_pkg::MAX_WINDOW];
  logic [swtf_pkg::SAMPLE_W-1:0]        old_q;
  logic signed [swtf_pkg::SAMPLE_W-1:0] y_q;
  logic [swtf_pkg::CNT_W-1:0]           wlen_q, wlen_new;
  logic [swtf_pkg::IDX_W-1:0]           slot_q, rd_addr;
  logic [swtf_pkg::CNT_W-1:0]           held_q;
  logic signed [swtf_pkg::SY_W-1:0]     sy_q;
  logic signed [swtf_pkg::SW_W-1:0]     sw_q;
  logic [swtf_pkg::SX_W-1:0]            sx_q;
  logic [swtf_pkg::SXX_W-1:0]           sxx_q;
  logic signed [swtf_pkg::PY_W-1:0]     py_q;
  logic                                 full;
  logic [swtf_pkg::CNT_W-1:0]           kmul;
  logic signed [swtf_pkg::SW_W-1:0]     y_ext, y0_ext, sy_ext, sw_d;
  logic signed [swtf_pkg::SY_W-1:0]     sy_d;

  swtf_pkg::op_t                        opd;
  logic [swtf_pkg::HALF_W-1:0]          small_v;
  logic signed [swtf_pkg::SW_W-1:0]     wide_v;
  logic signed [swtf_pkg::CHUNK_W-1:0]  chunk;
  logic signed [swtf_pkg::PROD_W-1:0]   prod_d, prod_q;
  logic signed [swtf_pkg::ACC_W-1:0]    term, base, acc_q;
  logic [swtf_pkg::D_W-1:0]             d_q;

  logic                                 neg_q;
  logic [swtf_pkg::ACC_W-1:0]           mag;
  logic [swtf_pkg::DIV_W-1:0]           dividend;
  logic                                 div_busy, div_ovf;
  logic [swtf_pkg::RES_W-1:0]           div_q, qsat, res;
  logic                                 sat;
  logic signed [swtf_pkg::RES_W-1:0]    slope_res_q, icpt_res_q;
  logic signed [swtf_pkg::RES_W-1:0]    slope_q, icpt_q;
  logic                                 fitv_q;
  logic [swtf_pkg::CNT_W-1:0]           held_out_q;

  assign wlen_new = swtf_pkg::clamp_window(cfg_wdata_i);
  assign full     = held_q >= wlen_q;
  assign kmul     = full ? held_q - 1'b1 : held_q;
  assign rd_addr  = slot_q - held_q[swtf_pkg::IDX_W-1:0];

  assign y_ext  = swtf_pkg::SW_W'(y_q);
  assign y0_ext = swtf_pkg::SW_W'($signed(old_q));
  assign sy_ext = swtf_pkg::SW_W'(sy_q);
  assign sy_d   = full ? sy_q + swtf_pkg::SY_W'(y_q) - swtf_pkg::SY_W'($signed(old_q))
                       : sy_q + swtf_pkg::SY_W'(y_q);
  assign sw_d   = full ? sw_q - (sy_ext - y0_ext) + swtf_pkg::SW_W'(py_q)
                       : sw_q + swtf_pkg::SW_W'(py_q);

  // ring memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      old_q <= ring_q[rd_addr];
      y_q   <= balance_sample_i;
    end
    if (cmd_i.upd_sums) ring_q[slot_q] <= y_q;
    if (cmd_i.prod_y) py_q <= $signed({1'b0, kmul}) * y_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q <= swtf_pkg::WIN_RESET;
      slot_q <= '0;
      held_q <= '0;
      sy_q   <= '0;
      sw_q   <= '0;
      sx_q   <= '0;
      sxx_q  <= '0;
    end else if (cfg_we_i) begin
      wlen_q <= wlen_new;
      if (held_q > wlen_new) begin
        slot_q <= '0;
        held_q <= '0;
        sy_q   <= '0;
        sw_q   <= '0;
        sx_q   <= '0;
        sxx_q  <= '0;
      end
    end else if (cmd_i.upd_sums) begin
      sy_q   <= sy_d;
      sw_q   <= sw_d;
      slot_q <= slot_q + 1'b1;
      if (!full) begin
        held_q <= held_q + 1'b1;
        sx_q   <= sx_q + swtf_pkg::SX_W'(held_q);
        sxx_q  <= sxx_q + swtf_pkg::SXX_W'(held_q) * swtf_pkg::SXX_W'(held_q);
      end
    end
  end

  // shared multiplier and accumulator
  always_comb begin
    opd = swtf_pkg::op_decode(cmd_i.op);
    case (opd.sm)
      swtf_pkg::SM_N:   small_v = swtf_pkg::HALF_W'(held_q);
      swtf_pkg::SM_SX:  small_v = swtf_pkg::HALF_W'(sx_q);
      default:          small_v = sxx_q;
    endcase
    case (opd.wd)
      swtf_pkg::WD_SXX: wide_v = swtf_pkg::SW_W'(sxx_q);
      swtf_pkg::WD_SX:  wide_v = swtf_pkg::SW_W'(sx_q);
      swtf_pkg::WD_SW:  wide_v = sw_q;
      default:          wide_v = sy_ext;
    endcase
    chunk = opd.hi ? $signed({wide_v[swtf_pkg::SW_W-1], wide_v[swtf_pkg::SW_W-1:swtf_pkg::HALF_W]})
                   : $signed({1'b0, wide_v[swtf_pkg::HALF_W-1:0]});
    prod_d = $signed({1'b0, small_v}) * chunk;
    term   = opd.hi ? (swtf_pkg::ACC_W'(prod_q) <<< swtf_pkg::HALF_W)
                    : swtf_pkg::ACC_W'(prod_q);
    base   = (cmd_i.op[1:0] == 2'd0) ? '0 : acc_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) prod_q <= prod_d;
    if (cmd_i.acc) acc_q <= opd.sub ? base - term : base + term;
    if (cmd_i.cap_d) d_q <= acc_q[swtf_pkg::D_W-1:0];
    if (cmd_i.div_start) neg_q <= acc_q[swtf_pkg::ACC_W-1];
  end

  // rounded scaled division
  assign mag      = acc_q[swtf_pkg::ACC_W-1] ? -acc_q : acc_q;
  assign dividend = {1'b0, mag, {swtf_pkg::FRAC_SH{1'b0}}} + swtf_pkg::DIV_W'(d_q);

  swtf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  ({d_q, 1'b0}),
    .busy_o     (div_busy),
    .quot_o     (div_q),
    .ovf_o      (div_ovf)
  );

  always_comb begin
    logic [swtf_pkg::RES_W-1:0] lim;
    lim  = neg_q ? {1'b1, {(swtf_pkg::RES_W-1){1'b0}}} : {1'b0, {(swtf_pkg::RES_W-1){1'b1}}};
    sat  = div_ovf || (div_q > lim);
    qsat = sat ? lim : div_q;
    res  = neg_q ? -qsat : qsat;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_res) begin
      if (cmd_i.op[3:2] == swtf_pkg::GRP_SLOPE) slope_res_q <= $signed(res);
      else icpt_res_q <= $signed(res);
    end
    if (cmd_i.out_load) begin
      fitv_q     <= status_o.fit_ok;
      held_out_q <= held_q;
      slope_q    <= status_o.fit_ok ? slope_res_q : '0;
      icpt_q     <= status_o.fit_ok ? icpt_res_q : '0;
    end
  end

  assign status_o.fit_ok   = held_q >= swtf_pkg::CNT_W'(2);
  assign status_o.div_busy = div_busy;

  assign trend_slope_o     = slope_q;
  assign trend_intercept_o = icpt_q;
  assign fit_valid_o       = fitv_q;
  assign samples_held_o    = held_out_q;

endmodule

/* design/swtf_ctrl.sv */
`timescale 1ns / 1ps
// controller: sequences sum update, multiply groups, divisions and result hand-off
// depends on swtf_pkg
module swtf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  swtf_pkg::status_t status_i,
  output swtf_pkg::cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UPD1,
    ST_UPD2,
    ST_CHK,
    ST_MUL,
    ST_ACC,
    ST_DSTART,
    ST_DWAIT,
    ST_FIN
  } state_e;

  state_e                      state_q;
  logic [swtf_pkg::OP_W-1:0]   op_q;
  logic                        out_valid_q;
  logic                        out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd_o           = '0;
    cmd_o.op        = op_q;
    cmd_o.accept    = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.prod_y    = state_q == ST_UPD1;
    cmd_o.upd_sums  = state_q == ST_UPD2;
    cmd_o.mul       = state_q == ST_MUL;
    cmd_o.acc       = state_q == ST_ACC;
    cmd_o.cap_d     = (state_q == ST_DSTART) && (op_q[3:2] == swtf_pkg::GRP_DEN);
    cmd_o.div_start = (state_q == ST_DSTART) && (op_q[3:2] != swtf_pkg::GRP_DEN);
    cmd_o.cap_res   = (state_q == ST_DWAIT) && !status_i.div_busy;
    cmd_o.out_load  = (state_q == ST_FIN) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= cmd_o.out_load || (out_valid_q && out_stall_i);
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) state_q <= ST_UPD1;
        end
        ST_UPD1: state_q <= ST_UPD2;
        ST_UPD2: state_q <= ST_CHK;
        ST_CHK: begin
          op_q    <= '0;
          state_q <= status_i.fit_ok ? ST_MUL : ST_FIN;
        end
        ST_MUL: state_q <= ST_ACC;
        ST_ACC: begin
          if (op_q[1:0] != 2'd3) begin
            op_q    <= op_q + 1'b1;
            state_q <= ST_MUL;
          end else begin
            state_q <= ST_DSTART;
          end
        end
        ST_DSTART: begin
          if (op_q[3:2] == swtf_pkg::GRP_DEN) begin
            op_q    <= op_q + 1'b1;
            state_q <= ST_MUL;
          end else begin
            state_q <= ST_DWAIT;
          end
        end
        ST_DWAIT: begin
          if (!status_i.div_busy) begin
            if (op_q[3:2] == swtf_pkg::GRP_SLOPE) begin
              op_q    <= op_q + 1'b1;
              state_q <= ST_MUL;
            end else begin
              state_q <= ST_FIN;
            end
          end
        end
        ST_FIN: begin
          if (out_free) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

/* design/sliding_window_trend_fit.sv */
`timescale 1ns / 1ps
// top level of the sliding window least-squares trend fit
// depends on swtf_pkg, swtf_ctrl, swtf_dp
//
//   channel  | handshake                | payload
//   ---------+--------------------------+-----------------------------------------
//   in       | in_valid_i / in_stall_o  | balance_sample_i
//   out      | out_valid_o / out_stall_i| trend_slope_o, trend_intercept_o,
//            |                          | fit_valid_o, samples_held_o
//   cfg      | cfg_we_i                 | cfg_wdata_i (window_length)
//
// one request at a time; a request with fewer than two samples skips the multiply and divide steps
// a fit uses the shared 2-bit-per-cycle divider, run once for slope and once
// for intercept, plus twelve passes through the shared multiplier
// reset empties the window and sets window_length to 365; no clearing pass is needed
// a stalled result stays in the output register while the next request is worked on
module sliding_window_trend_fit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [swtf_pkg::SAMPLE_W-1:0] balance_sample_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [swtf_pkg::RES_W-1:0]    trend_slope_o,
  output logic signed [swtf_pkg::RES_W-1:0]    trend_intercept_o,
  output logic                                 fit_valid_o,
  output logic [swtf_pkg::CNT_W-1:0]           samples_held_o,
  input  logic                                 cfg_we_i,
  input  logic [swtf_pkg::CNT_W-1:0]           cfg_wdata_i
);

  swtf_pkg::cmd_t    cmd;
  swtf_pkg::status_t status;

  swtf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  swtf_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .balance_sample_i  (balance_sample_i),
    .trend_slope_o     (trend_slope_o),
    .trend_intercept_o (trend_intercept_o),
    .fit_valid_o       (fit_valid_o),
    .samples_held_o    (samples_held_o)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while a request is in flight");

  a_fit_needs_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && fit_valid_o) |-> (samples_held_o >= swtf_pkg::CNT_W'(2)))
    else $error("fit reported with fewer than two samples");

  a_no_fit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !fit_valid_o) |-> (trend_slope_o == '0 && trend_intercept_o == '0))
    else $error("nonzero results without a fit");

  a_held_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (samples_held_o <= swtf_pkg::CNT_W'(swtf_pkg::MAX_WINDOW)))
    else $error("held count beyond window capacity");

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// self-checking testbench for sliding_window_trend_fit: drives samples and window settings,
// predicts each fit with exact wide integer math and compares every result in order
// depends on swtf_pkg and sliding_window_trend_fit
module tb;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int SETTLE       = 250;
  localparam int HOLD_CYCLES  = 400;

  typedef struct {
    logic signed [swtf_pkg::RES_W-1:0] slope;
    logic signed [swtf_pkg::RES_W-1:0] icpt;
    logic                              fit_ok;
    logic [swtf_pkg::CNT_W-1:0]        held;
  } fit_t;

  class fit_scoreboard;
    fit_t                    pending[$];
    int                      errors;
    logic signed [swtf_pkg::SAMPLE_W-1:0] ring[swtf_pkg::MAX_WINDOW];
    int                      slot, cnt, win;
    longint                  sum_y, sum_wy;

    function new();
      errors = 0;
      win = 365;
      clear_window();
    endfunction

    function void clear_window();
      slot = 0; cnt = 0; sum_y = 0; sum_wy = 0;
    endfunction

    function void write_window(logic [swtf_pkg::CNT_W-1:0] v);
      win = (v < 2) ? 2 : ((v > swtf_pkg::MAX_WINDOW) ? swtf_pkg::MAX_WINDOW : int'(v));
      if (cnt > win) clear_window();
    endfunction

    function logic [swtf_pkg::RES_W-1:0] scaled_div(logic signed [127:0] num,
                                                    logic [127:0] d);
      logic        neg;
      logic [127:0] m, q, lim;
      neg = num[127];
      m = neg ? -num : num;
      m = (m << swtf_pkg::FRAC_SH) + d;
      q = m / (d << 1);
      lim = neg ? (128'd1 << 47) : ((128'd1 << 47) - 1);
      if (q > lim) q = lim;
      if (neg) q = -q;
      return q[swtf_pkg::RES_W-1:0];
    endfunction

    function void note_sample(logic signed [swtf_pkg::SAMPLE_W-1:0] s);
      longint y, y0, n, sx, sxx, d;
      int     oldest;
      logic signed [127:0] wn, wsx, wsxx, wy, wwy;
      fit_t   e;
      y = s;
      if (cnt >= win) begin
        oldest = (slot >= cnt) ? slot - cnt : slot + swtf_pkg::MAX_WINDOW - cnt;
        y0 = ring[oldest];
        sum_wy -= sum_y - y0;
        sum_wy += longint'(cnt - 1) * y;
        sum_y += y - y0;
      end else begin
        sum_wy += longint'(cnt) * y;
        sum_y += y;
        cnt++;
      end
      ring[slot] = s;
      slot = (slot + 1 >= swtf_pkg::MAX_WINDOW) ? 0 : slot + 1;
      e.slope = '0; e.icpt = '0; e.fit_ok = 1'b0; e.held = cnt[swtf_pkg::CNT_W-1:0];
      if (cnt >= 2) begin
        n = cnt;
        sx = n * (n - 1) / 2;
        sxx = (n - 1) * n * (2 * n - 1) / 6;
        d = n * sxx - sx * sx;
        wn = n; wsx = sx; wsxx = sxx; wy = sum_y; wwy = sum_wy;
        e.slope = scaled_div(wn * wwy - wsx * wy, 128'(d));
        e.icpt = scaled_div(wsxx * wy - wsx * wwy, 128'(d));
        e.fit_ok = 1'b1;
      end
      pending.insert(pending.size(), e);
    endfunction

    task report(string what);
      errors++;
      $display("error at %0t: %s", $realtime, what);
    endtask

    task check_result(fit_t got);
      fit_t e;
      if (pending.size() == 0) begin
        report("result with no request outstanding");
        return;
      end
      e = pending.pop_front();
      if (got.slope !== e.slope)
        report($sformatf("slope %0d, expected %0d", got.slope, e.slope));
      if (got.icpt !== e.icpt)
        report($sformatf("intercept %0d, expected %0d", got.icpt, e.icpt));
      if (got.fit_ok !== e.fit_ok)
        report($sformatf("fit_valid %0b, expected %0b", got.fit_ok, e.fit_ok));
      if (got.held !== e.held)
        report($sformatf("samples_held %0d, expected %0d", got.held, e.held));
    endtask
  endclass

  logic                                 clk_i = 1'b0;
  logic                                 rst_ni = 1'b0;
  logic                                 in_valid_i = 1'b0;
  logic                                 in_stall_o;
  logic signed [swtf_pkg::SAMPLE_W-1:0] balance_sample_i = '0;
  logic                                 out_valid_o;
  logic                                 out_stall_i = 1'b0;
  logic signed [swtf_pkg::RES_W-1:0]    trend_slope_o, trend_intercept_o;
  logic                                 fit_valid_o;
  logic [swtf_pkg::CNT_W-1:0]           samples_held_o;
  logic                                 cfg_we_i = 1'b0;
  logic [swtf_pkg::CNT_W-1:0]           cfg_wdata_i = '0;

  fit_scoreboard sb = new();
  bit  quiet = 1'b0;
  bit  hold_go = 1'b0;
  bit  hold_done = 1'b0;
  int  hold_cnt = 0;
  int  cycles = 0;

  sliding_window_trend_fit uut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .balance_sample_i,
    .out_valid_o, .out_stall_i, .trend_slope_o, .trend_intercept_o,
    .fit_valid_o, .samples_held_o, .cfg_we_i, .cfg_wdata_i
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("sliding_window_trend_fit: mismatch");
      $finish;
    end
  end

  // receiver side, including one long hold-off
  always @(negedge clk_i) begin
    if (hold_go && !hold_done) begin
      out_stall_i = 1'b1;
      hold_cnt++;
      if (hold_cnt >= HOLD_CYCLES) hold_done = 1'b1;
    end else begin
      out_stall_i = !quiet && ($urandom_range(0, 99) < 15);
    end
  end

  always @(posedge clk_i) begin
    fit_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.slope = trend_slope_o;
      got.icpt = trend_intercept_o;
      got.fit_ok = fit_valid_o;
      got.held = samples_held_o;
      sb.check_result(got);
    end
  end

  task send_sample(logic signed [swtf_pkg::SAMPLE_W-1:0] s);
    @(negedge clk_i);
    while (!quiet && $urandom_range(0, 99) < 15) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    balance_sample_i = s;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_sample(s);
  endtask

  task drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task write_window(logic [swtf_pkg::CNT_W-1:0] v);
    drain();
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.write_window(v);
  endtask

  function logic signed [swtf_pkg::SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return $signed($urandom_range(0, 200)) - 100;
      3: return $signed($urandom_range(0, 2000000)) - 1000000;
      default: return $urandom;
    endcase
  endfunction

  int windows[10] = '{2, 3, 512, 17, 600, 5, 1, 365, 100, 1023};

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset window, first sample gives no fit
    send_sample(32'sh7fff_ffff);
    send_sample(32'sh8000_0000);
    send_sample(32'sh7fff_ffff);
    send_sample(32'sh0);
    send_sample(-32'sh1);
    send_sample(32'sh1);
    send_sample(32'sh5555_5555);
    send_sample(32'shaaaa_aaaa);
    // below minimum, window shrinks and empties
    write_window(10'd0);
    send_sample(32'sh7fff_ffff);
    send_sample(32'sh8000_0000);
    send_sample(32'sh7fff_ffff);
    send_sample(32'sh8000_0000);
    // above maximum, held samples kept
    write_window(10'd1023);
    send_sample(32'sh0);
    send_sample(32'sh7fff_ffff);
    write_window(10'd2);
    send_sample(-32'sh1);

    foreach (windows[p]) begin
      write_window(swtf_pkg::CNT_W'(windows[p]));
      quiet = (p == 4);
      if (p == 2) hold_go = 1'b1;
      for (int i = 0; i < 40; i++) send_sample(pick_sample());
    end
    quiet = 1'b0;

    drain();
    if (sb.errors == 0) begin
      $display("sliding_window_trend_fit: match");
    end else begin
      $display("sliding_window_trend_fit: mismatch");
    end
    $finish;
  end

endmodule

/* sim.f */
design/swtf_pkg.sv
design/swtf_div.sv
design/swtf_dp.sv
design/swtf_ctrl.sv
design/sliding_window_trend_fit.sv
tb/tb.sv
